// ===== rtl/swrl_pkg.sv =====
// Shared types and constants for the sliding window rate limiter.
// No dependencies; used by swrl_core and sliding_window_rate_limiter.
`timescale 1ns / 1ps

package swrl_pkg;

    // Configuration register indexes.
    localparam logic [0:0] CFG_MAX_REQUESTS = 1'd0;
    localparam logic [0:0] CFG_WINDOW_LEN   = 1'd1;

    // Register reset values.
    localparam logic [4:0]  MAX_REQUESTS_RST = 5'd5;
    localparam logic [15:0] WINDOW_LEN_RST   = 16'd60;

    // Stream payload widths.
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 8;

    // Live configuration handed to the core.
    typedef struct packed {
        logic [4:0]  max_requests;
        logic [15:0] window_len;
    } t_cfg;

endpackage

// ===== rtl/sliding_window_rate_limiter.sv =====
// Top level of the per-user sliding window log rate limiter: stream ports,
// configuration registers and output register. Depends on swrl_pkg, swrl_core.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake                         Payload
//  -------   ---------  --------------------------------  ------------------------------
//  s_axis    in         i_s_axis_tvalid / o_s_axis_tready  [3:0] user_index, [35:4] timestamp
//  m_axis    out        o_m_axis_tvalid / i_m_axis_tready  [0] allowed
//  cfg       in         i_cfg_valid / o_cfg_ready          index, [15:0] data
//
// One item is processed at a time: the core loads the user's head and count, compares
// logged timestamps against the window while evicting expired entries (the scan stops
// at the first entry still in the window or when the log is empty), then decides and
// holds the result. The eviction loop reads one logged timestamp per cycle from the
// single read port of the log memory. After reset the block clears the per-user
// head/count table, one user per cycle, before the first item is accepted;
// configuration writes are taken at any time. A stalled output holds the finished
// result in the core until the output register drains.

module sliding_window_rate_limiter #(
    parameter int NUM_USERS = 16,
    parameter int MAX_LOG   = 16,
    parameter int TIME_BITS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Request items.
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // [3:0] user_index, [35:4] timestamp, [39:36] zero
    input  logic [swrl_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // Result items.
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [0] allowed, [7:1] zero
    output logic [swrl_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    // Register writes.
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [0:0]                       i_cfg_index,
    input  logic [15:0]                      i_cfg_data
);

    localparam int UW = (NUM_USERS > 1) ? $clog2(NUM_USERS) : 1;

    logic [4:0]           r_max_requests;
    logic [15:0]          r_window_len;
    logic                 r_out_valid;
    logic                 r_out_allowed;

    swrl_pkg::t_cfg       cfg;
    logic [3:0]           in_user;
    logic [31:0]          in_time;
    logic [15:0]          user_wide;
    logic [63:0]          time_wide;
    logic                 in_range;
    logic                 res_valid;
    logic                 res_ready;
    logic                 res_allowed;

    // Registers can always be written. The core reads them while an item is
    // being processed, so they must only change while no item is in flight.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_requests <= swrl_pkg::MAX_REQUESTS_RST;
            r_window_len   <= swrl_pkg::WINDOW_LEN_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                swrl_pkg::CFG_MAX_REQUESTS: r_max_requests <= i_cfg_data[4:0];
                swrl_pkg::CFG_WINDOW_LEN:   r_window_len   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign cfg.max_requests = r_max_requests;
    assign cfg.window_len   = r_window_len;

    // Unpack the request. Users at or above NUM_USERS are denied without a lookup,
    // and timestamps are kept modulo 2^TIME_BITS.
    assign in_user   = i_s_axis_tdata[3:0];
    assign in_time   = i_s_axis_tdata[35:4];
    assign user_wide = {12'd0, in_user};
    assign time_wide = {32'd0, in_time};
    assign in_range  = ({7'd0, in_user} < 11'(NUM_USERS));

    swrl_core #(
        .NUM_USERS (NUM_USERS),
        .MAX_LOG   (MAX_LOG),
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_req_valid    (i_s_axis_tvalid),
        .o_req_ready    (o_s_axis_tready),
        .i_req_in_range (in_range),
        .i_req_user     (user_wide[UW-1:0]),
        .i_req_now      (time_wide[TIME_BITS-1:0]),
        .o_res_valid    (res_valid),
        .i_res_ready    (res_ready),
        .o_res_allowed  (res_allowed)
    );

    // Output register: takes a result whenever it is empty or being drained.
    assign res_ready = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out_allowed <= res_allowed;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out_allowed};

endmodule

// ===== rtl/swrl_core.sv =====
// Request engine of the rate limiter: per-user ring state memory, timestamp log
// memory, eviction loop and admit decision. Depends on swrl_pkg.
`timescale 1ns / 1ps

module swrl_core #(
    parameter int NUM_USERS = 16,
    parameter int MAX_LOG   = 16,
    parameter int TIME_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  swrl_pkg::t_cfg       i_cfg,
    input  logic                 i_req_valid,
    output logic                 o_req_ready,
    input  logic                 i_req_in_range,
    input  logic [$clog2((NUM_USERS > 1) ? NUM_USERS : 2)-1:0] i_req_user,
    input  logic [TIME_BITS-1:0] i_req_now,
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output logic                 o_res_allowed
);

    localparam int UW   = (NUM_USERS > 1) ? $clog2(NUM_USERS) : 1;
    localparam int AW   = (NUM_USERS * MAX_LOG > 1) ? $clog2(NUM_USERS * MAX_LOG) : 1;
    localparam int HW   = (MAX_LOG > 1) ? $clog2(MAX_LOG) : 1;
    localparam int CW   = $clog2(MAX_LOG + 1);
    localparam int SW   = CW + 1;
    localparam int STW  = HW + CW;
    localparam int CMPW = (TIME_BITS > 16) ? TIME_BITS : 16;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_LOAD   = 3'd2;
    localparam logic [2:0] ST_EVICT  = 3'd3;
    localparam logic [2:0] ST_DECIDE = 3'd4;
    localparam logic [2:0] ST_HOLD   = 3'd5;

    // Per-user {head, count} and the timestamp rings.
    logic [STW-1:0]       user_mem [NUM_USERS];
    logic [TIME_BITS-1:0] time_mem [NUM_USERS * MAX_LOG];

    logic [2:0]           r_state, n_state;
    logic [UW-1:0]        r_clr, n_clr;
    logic [HW-1:0]        r_head, n_head;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic                 r_allowed, n_allowed;
    logic [UW-1:0]        r_user;
    logic [AW-1:0]        r_base;
    logic [TIME_BITS-1:0] r_now;
    logic [STW-1:0]       r_user_q;
    logic [TIME_BITS-1:0] r_time_q;

    logic                 accept;
    logic                 umem_we;
    logic [UW-1:0]        umem_waddr;
    logic [STW-1:0]       umem_wdata;
    logic                 tmem_re;
    logic [AW-1:0]        tmem_raddr;
    logic                 tmem_we;
    logic [AW-1:0]        tmem_waddr;
    logic [HW-1:0]        q_head;
    logic [CW-1:0]        q_cnt;
    logic [HW-1:0]        head_adv;
    logic [SW-1:0]        tail_sum;
    logic [SW-1:0]        tail_wrap;
    logic [TIME_BITS-1:0] diff;
    logic                 expired;
    logic [8:0]           max_req9;
    logic [8:0]           limit;
    logic                 over_limit;

    assign o_req_ready   = (r_state == ST_IDLE);
    assign o_res_valid   = (r_state == ST_HOLD);
    assign o_res_allowed = r_allowed;
    assign accept        = i_req_valid && o_req_ready;

    assign q_head   = r_user_q[STW-1:CW];
    assign q_cnt    = r_user_q[CW-1:0];
    assign head_adv = (r_head == HW'(MAX_LOG - 1)) ? '0 : r_head + HW'(1);

    // Slot after the newest entry, modulo the ring depth.
    assign tail_sum   = SW'(r_head) + SW'(r_cnt);
    assign tail_wrap  = (tail_sum >= SW'(MAX_LOG)) ? tail_sum - SW'(MAX_LOG) : tail_sum;
    assign tmem_waddr = r_base + AW'(tail_wrap[HW-1:0]);

    // A negative signed difference never expires an entry.
    assign diff    = r_now - r_time_q;
    assign expired = !diff[TIME_BITS-1] && (CMPW'(diff) > CMPW'(i_cfg.window_len));

    assign max_req9   = {4'd0, i_cfg.max_requests};
    assign limit      = (max_req9 < 9'(MAX_LOG)) ? max_req9 : 9'(MAX_LOG);
    assign over_limit = (9'(r_cnt) >= limit);

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_head     = r_head;
        n_cnt      = r_cnt;
        n_allowed  = r_allowed;
        umem_we    = 1'b0;
        umem_waddr = r_user;
        umem_wdata = {r_head, r_cnt};
        tmem_re    = 1'b0;
        tmem_raddr = r_base + AW'(head_adv);
        tmem_we    = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                umem_we    = 1'b1;
                umem_waddr = r_clr;
                umem_wdata = '0;
                n_clr      = r_clr + UW'(1);
                if (r_clr == UW'(NUM_USERS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_req_valid) begin
                    if (i_req_in_range) begin
                        n_state = ST_LOAD;
                    end else begin
                        n_allowed = 1'b0;
                        n_state   = ST_HOLD;
                    end
                end
            end
            ST_LOAD: begin
                n_head = q_head;
                n_cnt  = q_cnt;
                if (q_cnt != '0) begin
                    tmem_re    = 1'b1;
                    tmem_raddr = r_base + AW'(q_head);
                    n_state    = ST_EVICT;
                end else begin
                    n_state = ST_DECIDE;
                end
            end
            ST_EVICT: begin
                // The oldest entry is on the read port; if it has expired, drop it and fetch the next.
                if (expired) begin
                    n_head = head_adv;
                    n_cnt  = r_cnt - CW'(1);
                    if (r_cnt != CW'(1)) begin
                        tmem_re = 1'b1;
                    end else begin
                        n_state = ST_DECIDE;
                    end
                end else begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                umem_we = 1'b1;
                if (over_limit) begin
                    n_allowed = 1'b0;
                end else begin
                    n_allowed  = 1'b1;
                    tmem_we    = 1'b1;
                    n_cnt      = r_cnt + CW'(1);
                    umem_wdata = {r_head, r_cnt + CW'(1)};
                end
                n_state = ST_HOLD;
            end
            ST_HOLD: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head    <= n_head;
        r_cnt     <= n_cnt;
        r_allowed <= n_allowed;
        if (accept) begin
            r_user <= i_req_user;
            r_base <= AW'(i_req_user) * AW'(MAX_LOG);
            r_now  <= i_req_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (umem_we) begin
            user_mem[umem_waddr] <= umem_wdata;
        end
        if (accept) begin
            r_user_q <= user_mem[i_req_user];
        end
    end

    always_ff @(posedge i_clk) begin
        if (tmem_we) begin
            time_mem[tmem_waddr] <= r_now;
        end
        if (tmem_re) begin
            r_time_q <= time_mem[tmem_raddr];
        end
    end

endmodule
